@@ rtl/core/rotary_encoder_with_key_press_assert.svh @@
// assertion macros for the rotary encoder block checker
// expects signals named clk and rst in the scope of use
`ifndef ROTARY_ENCODER_WITH_KEY_PRESS_ASSERT_SVH
`define ROTARY_ENCODER_WITH_KEY_PRESS_ASSERT_SVH

// property checked on every clock edge outside reset
`define REKP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define REKP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rekp_pkg.sv @@
// shared types and codes for the rotary encoder with key block
// no dependencies
package rekp_pkg;

  // default detent counter width
  localparam int COUNT_WIDTH_DEF = 16;

  // register indexes on the config port
  localparam logic [1:0] REG_REVERSE_DIR = 2'd0;
  localparam logic [1:0] REG_LONG_TICKS  = 2'd1;
  localparam logic [1:0] REG_MIN_TICKS   = 2'd2;

  // register reset values
  localparam logic [15:0] LONG_TICKS_RST = 16'd1000;
  localparam logic [15:0] MIN_TICKS_RST  = 16'd10;

  // request types
  localparam logic [1:0] REQ_PIN  = 2'd0;
  localparam logic [1:0] REQ_KEY  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // last move codes
  localparam logic [1:0] MOVE_NONE = 2'd0;
  localparam logic [1:0] MOVE_UP   = 2'd1;
  localparam logic [1:0] MOVE_DOWN = 2'd2;

  // key phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_SHORT   = 2'd2;
  localparam logic [1:0] PH_LONG    = 2'd3;

  // event code bases and limits
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_DOWN      = 4'd2;
  localparam logic [3:0] EV_SHORT     = 4'd3;
  localparam logic [3:0] EV_SHORT_DN  = 4'd5;
  localparam logic [3:0] EV_LONG      = 4'd6;
  localparam logic [3:0] EV_LONG_DOWN = 4'd8;

  // configuration register set
  typedef struct packed {
    logic        reverse_dir;
    logic [15:0] long_press_ticks;
    logic [15:0] min_press_ticks;
  } cfg_t;

endpackage

@@ rtl/core/rekp_cfg.sv @@
// apb register file for the rotary encoder with key block
// depends on rekp_pkg
module rekp_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rekp_pkg::cfg_t     cfg
);
  import rekp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_dir      <= 1'b0;
      cfg.long_press_ticks <= LONG_TICKS_RST;
      cfg.min_press_ticks  <= MIN_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_REVERSE_DIR: cfg.reverse_dir      <= pwdata[0];
        REG_LONG_TICKS:  cfg.long_press_ticks <= pwdata[15:0];
        REG_MIN_TICKS:   cfg.min_press_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_REVERSE_DIR: prdata = {31'd0, cfg.reverse_dir};
      REG_LONG_TICKS:  prdata = {16'd0, cfg.long_press_ticks};
      REG_MIN_TICKS:   prdata = {16'd0, cfg.min_press_ticks};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/rekp_core.sv @@
// decoder state and next-state logic: quadrature capture, key machine, event read
// depends on rekp_pkg
module rekp_core #(
  parameter int COUNT_WIDTH = rekp_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [1:0]         req_type,
  input  logic               a_level,
  input  logic               b_level,
  input  logic               key_level,
  input  logic [31:0]        now_tick,
  input  rekp_pkg::cfg_t     cfg,
  output logic [3:0]         event_code,
  output logic [15:0]        position,
  output logic [1:0]         key_phase
);
  import rekp_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic                   capture_armed, capture_armed_next;
  logic                   b_latched, b_latched_next;
  logic [1:0]             last_move, last_move_next;
  logic [COUNT_WIDTH-1:0] detent_count, detent_count_next;
  logic [1:0]             press_phase, press_phase_next;
  logic [31:0]            press_start, press_start_next;

  logic [31:0]            held;
  logic                   reach_long;
  logic                   reach_min;
  logic [3:0]             ev_base;
  logic [EXT_W-1:0]       count_ext;

  assign held       = now_tick - press_start;
  assign reach_long = held >= {16'd0, cfg.long_press_ticks};
  assign reach_min  = held >= {16'd0, cfg.min_press_ticks};

  // event base from the key phase
  always_comb begin
    case (press_phase)
      PH_SHORT: ev_base = EV_SHORT;
      PH_LONG:  ev_base = EV_LONG;
      default:  ev_base = EV_NONE;
    endcase
  end

  // next state for one transaction
  always_comb begin
    capture_armed_next = capture_armed;
    b_latched_next     = b_latched;
    last_move_next     = last_move;
    detent_count_next  = detent_count;
    press_phase_next   = press_phase;
    press_start_next   = press_start;
    event_code         = EV_NONE;
    case (req_type)
      REQ_PIN: begin
        if (!a_level && !capture_armed) begin
          capture_armed_next = 1'b1;
          b_latched_next     = b_level;
        end
        if (a_level && capture_armed) begin
          capture_armed_next = 1'b0;
          if (b_latched != b_level) begin
            // falling b counts up in clockwise sense
            if ((b_latched & ~b_level) ^ cfg.reverse_dir) begin
              detent_count_next = detent_count + COUNT_WIDTH'(1);
              last_move_next    = MOVE_UP;
            end else begin
              detent_count_next = detent_count - COUNT_WIDTH'(1);
              last_move_next    = MOVE_DOWN;
            end
          end
        end
      end
      REQ_KEY: begin
        if (!key_level) begin
          if (press_phase == PH_IDLE) begin
            press_phase_next = PH_PRESSED;
            press_start_next = now_tick;
          end else if (press_phase == PH_PRESSED && reach_long) begin
            press_phase_next = PH_LONG;
          end
        end else if (press_phase == PH_PRESSED) begin
          // early release keeps the pressed phase
          if (reach_long) begin
            press_phase_next = PH_LONG;
          end else if (reach_min) begin
            press_phase_next = PH_SHORT;
          end
        end else begin
          press_phase_next = PH_IDLE;
          press_start_next = now_tick;
        end
      end
      REQ_READ: begin
        event_code     = ev_base + {2'd0, last_move};
        last_move_next = MOVE_NONE;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_armed <= 1'b0;
      b_latched     <= 1'b0;
      last_move     <= MOVE_NONE;
      detent_count  <= '0;
      press_phase   <= PH_IDLE;
      press_start   <= 32'd0;
    end else if (fire) begin
      capture_armed <= capture_armed_next;
      b_latched     <= b_latched_next;
      last_move     <= last_move_next;
      detent_count  <= detent_count_next;
      press_phase   <= press_phase_next;
      press_start   <= press_start_next;
    end
  end

  // reported values follow the update
  assign count_ext = EXT_W'(signed'(detent_count_next));
  assign position  = count_ext[15:0];
  assign key_phase = press_phase_next;

endmodule

@@ rtl/core/rotary_encoder_with_key_press.sv @@
// top level of the rotary encoder with key block: stream ports, apb config
// depends on rekp_pkg, rekp_cfg, rekp_core
// path from input transaction to result: input register, then result register
// throughput: one transaction per cycle unless the output stalls; both register stages advance together
// a stalled output holds its result while the input register may still fill
// reset: synchronous active high; clears stage valids, decoder state and config registers
module rotary_encoder_with_key_press #(
  parameter int COUNT_WIDTH = rekp_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // a_level, b_level, key_level, now_tick[31:0], 5'b0
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // event_code[3:0], position[15:0], key_phase[1:0], 2'b0
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rekp_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic [1:0]  in_req;
  logic        in_a, in_b, in_key;
  logic [31:0] in_tick;
  logic        adv;
  logic [3:0]  res_code;
  logic [15:0] res_pos;
  logic [1:0]  res_phase;
  logic [3:0]  out_code;
  logic [15:0] out_pos;
  logic [1:0]  out_phase;

  rekp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline handshake
  assign adv      = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= s_tuser;
      in_a    <= s_tdata[0];
      in_b    <= s_tdata[1];
      in_key  <= s_tdata[2];
      in_tick <= s_tdata[34:3];
    end
  end

  rekp_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (adv),
    .req_type   (in_req),
    .a_level    (in_a),
    .b_level    (in_b),
    .key_level  (in_key),
    .now_tick   (in_tick),
    .cfg        (cfg),
    .event_code (res_code),
    .position   (res_pos),
    .key_phase  (res_phase)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_code  <= res_code;
      out_pos   <= res_pos;
      out_phase <= res_phase;
    end
  end

  assign m_tdata = {2'b00, out_phase, out_pos, out_code};

endmodule

@@ rtl/core/rekp_chk.sv @@
// port-level checker for the rotary encoder with key block, bound to the top level
// depends on rekp_pkg and rotary_encoder_with_key_press_assert.svh
`include "rotary_encoder_with_key_press_assert.svh"

module rekp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import rekp_pkg::*;

  logic [3:0] code;
  logic [1:0] phase;
  logic       undecided;
  logic       short_ev;
  logic       long_ev;

  assign code  = m_tdata[3:0];
  assign phase = m_tdata[21:20];

  // event classes by key phase
  assign undecided = (phase == PH_IDLE) || (phase == PH_PRESSED);
  assign short_ev  = (code == EV_NONE) || (code >= EV_SHORT && code <= EV_SHORT_DN);
  assign long_ev   = (code == EV_NONE) || (code >= EV_LONG && code <= EV_LONG_DOWN);

  // stalled result stays offered
  `REKP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // no key event while idle or pressed
  `REKP_ASSERT(a_ev_idle, m_tvalid && undecided |-> code <= EV_DOWN, "key event before decision")

  // short phase reports only short events
  `REKP_ASSERT(a_ev_short, m_tvalid && phase == PH_SHORT |-> short_ev, "bad short phase event")

  // long phase reports only long events
  `REKP_ASSERT(a_ev_long, m_tvalid && phase == PH_LONG |-> long_ev, "bad long phase event")

  // pipeline empty and ready right after reset
  `REKP_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !m_tvalid && s_tready, "not empty after reset")

endmodule

bind rotary_encoder_with_key_press rekp_chk u_rekp_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for rotary_encoder_with_key_press: encoder, key and read transactions
// depends on rekp_pkg and the top level; self-checking against a local predictor
module tb_top;
  import rekp_pkg::*;

  // codes not named in the package
  localparam bit [1:0]   REQ_UNKNOWN = 2'd3;
  localparam logic [3:0] EV_UP       = 4'd1;

  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned MAX_REPORTS     = 100;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned SPIN_DETENTS    = 40;

  typedef struct packed {
    bit [1:0]  req;
    bit        a;
    bit        b;
    bit        key;
    bit [31:0] tick;
  } enc_item_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [15:0] pos;
    logic [1:0]  phase;
  } enc_result_t;

  typedef struct {
    enc_item_t   item;
    bit          typed;
    enc_result_t res;
  } enc_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // a_level, b_level, key_level, now_tick[31:0], 5'b0
  logic [1:0]  s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // event_code[3:0], position[15:0], key_phase[1:0], 2'b0
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the configuration and decoder state
  bit          cfg_reverse;
  bit [15:0]   cfg_long_ticks;
  bit [15:0]   cfg_min_ticks;
  bit          armed_st;
  bit          b_latched_st;
  bit [1:0]    last_move_st;
  bit [15:0]   detent_st;
  bit [1:0]    phase_st;
  bit [31:0]   press_start_st;

  enc_result_t expected_results[$];
  enc_row_t    directed_rows[$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          no_idle;

  rotary_encoder_with_key_press i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_span(input bit allow_zero);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one detent step of the wrapping counter
  function automatic void step_count(input bit up);
    if (up) begin
      detent_st    = detent_st + 16'd1;
      last_move_st = MOVE_UP;
    end else begin
      detent_st    = detent_st - 16'd1;
      last_move_st = MOVE_DOWN;
    end
  endfunction

  // advance the decoder state by one transaction and return its result
  function automatic enc_result_t predict_encoder(input enc_item_t it);
    enc_result_t r;
    bit [31:0]   held;
    logic [3:0]  base;
    r.code = EV_NONE;
    case (it.req)
      REQ_PIN: begin
        if (!it.a && !armed_st) begin
          armed_st     = 1'b1;
          b_latched_st = it.b;
        end else if (it.a && armed_st) begin
          armed_st = 1'b0;
          // equal b levels only disarm
          if (b_latched_st && !it.b) step_count(!cfg_reverse);
          else if (!b_latched_st && it.b) step_count(cfg_reverse);
        end
      end
      REQ_KEY: begin
        held = it.tick - press_start_st;
        if (!it.key) begin
          if (phase_st == PH_IDLE) begin
            phase_st       = PH_PRESSED;
            press_start_st = it.tick;
          end else if (phase_st == PH_PRESSED && held >= 32'(cfg_long_ticks)) begin
            phase_st = PH_LONG;
          end
        end else if (phase_st == PH_PRESSED) begin
          // early release keeps the pressed phase
          if (held >= 32'(cfg_min_ticks) && held < 32'(cfg_long_ticks)) phase_st = PH_SHORT;
          else if (held >= 32'(cfg_long_ticks)) phase_st = PH_LONG;
        end else begin
          phase_st       = PH_IDLE;
          press_start_st = it.tick;
        end
      end
      REQ_READ: begin
        base = EV_NONE;
        if (phase_st == PH_SHORT) base = EV_SHORT;
        else if (phase_st == PH_LONG) base = EV_LONG;
        r.code       = base + 4'(last_move_st);
        last_move_st = MOVE_NONE;
      end
      default: ;
    endcase
    r.pos   = detent_st;
    r.phase = phase_st;
    return r;
  endfunction

  // drive one transaction, wait for acceptance and queue its expected result
  task automatic send_item(input enc_item_t it, input bit typed, input enc_result_t typed_res);
    int unsigned gap;
    enc_result_t pred;
    gap = no_idle ? 0 : idle_span(1'b1);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req;
    s_tdata  <= {5'b0, it.tick, it.key, it.b, it.a};
    do @(posedge clk); while (!s_tready);
    pred = predict_encoder(it);
    expected_results.push_back(typed ? typed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // unused fields carry random values
  function automatic enc_item_t rand_item(input bit [1:0] req);
    enc_item_t it;
    it.req  = req;
    it.a    = 1'($urandom);
    it.b    = 1'($urandom);
    it.key  = 1'($urandom);
    it.tick = $urandom();
    return it;
  endfunction

  task automatic send_pin(input bit a, input bit b);
    enc_item_t it;
    it   = rand_item(REQ_PIN);
    it.a = a;
    it.b = b;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_key(input bit key, input bit [31:0] tick);
    enc_item_t it;
    it      = rand_item(REQ_KEY);
    it.key  = key;
    it.tick = tick;
    send_item(it, 1'b0, '0);
  endtask

  task automatic send_read();
    send_item(rand_item(REQ_READ), 1'b0, '0);
  endtask

  // one detent, optionally with contact bounce or an unchanged b level
  task automatic run_detent(input bit up, input bit bounce);
    bit first_b;
    first_b = up;
    if (bounce) send_pin(1'b1, 1'($urandom));
    send_pin(1'b0, first_b);
    if (bounce) repeat ($urandom_range(1, 2)) send_pin(1'b0, 1'($urandom));
    if ($urandom_range(0, 9) == 0) send_pin(1'b1, first_b);
    else send_pin(1'b1, !first_b);
  endtask

  // press, optional held scans, release mostly near the thresholds, then a later release
  task automatic run_key_press();
    bit [31:0] t0;
    bit [31:0] target;
    t0 = $urandom();
    case ($urandom_range(0, 5))
      0:       target = 32'(cfg_min_ticks) - 32'd1;
      1:       target = 32'(cfg_min_ticks);
      2:       target = 32'(cfg_long_ticks) - 32'd1;
      3:       target = 32'(cfg_long_ticks);
      4:       target = 32'(cfg_long_ticks) + $urandom_range(1, 50);
      default: target = $urandom_range(0, 32'(cfg_long_ticks) * 3 / 2 + 2);
    endcase
    send_key(1'b0, t0);
    repeat ($urandom_range(0, 3)) send_key(1'b0, t0 + $urandom_range(0, target));
    if ($urandom_range(0, 3) == 0) send_read();
    send_key(1'b1, t0 + target);
    if ($urandom_range(0, 2) == 0) send_key(1'b1, t0 + target + $urandom_range(0, 64));
    if ($urandom_range(0, 1) == 0) send_key(1'b0, t0 + target + $urandom_range(65, 200));
    if ($urandom_range(0, 2) != 0) send_read();
    send_key(1'b1, t0 + target + $urandom_range(201, 400));
  endtask

  // hold the source until every expected result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_REVERSE_DIR: cfg_reverse    = value[0];
      REG_LONG_TICKS:  cfg_long_ticks = value[15:0];
      REG_MIN_TICKS:   cfg_min_ticks  = value[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_config(input bit rev, input bit [15:0] long_t, input bit [15:0] min_t);
    apb_write(REG_REVERSE_DIR, 32'(rev));
    apb_write(REG_LONG_TICKS, 32'(long_t));
    apb_write(REG_MIN_TICKS, 32'(min_t));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // mix of well-formed detents and presses, reads, raw noise, gapless detent runs and settles
  task automatic run_random(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned sel;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        no_idle = 1'b1;
        repeat ($urandom_range(10, 30)) run_detent(1'($urandom), 1'b0);
        no_idle = 1'b0;
      end else if (sel < 6) begin
        settle();
      end else if (sel < 45) begin
        run_detent(1'($urandom), $urandom_range(0, 4) == 0);
      end else if (sel < 65) begin
        run_key_press();
      end else if (sel < 82) begin
        send_read();
      end else begin
        send_item(rand_item(2'($urandom)), 1'b0, '0);
      end
    end
  endtask

  function automatic void add_row(input bit [1:0] req, input bit a, input bit b, input bit key,
                                  input bit [31:0] tick, input bit typed, input logic [3:0] code,
                                  input logic [15:0] pos, input logic [1:0] ph);
    enc_row_t row;
    row.item  = '{req: req, a: a, b: b, key: key, tick: tick};
    row.typed = typed;
    row.res   = '{code: code, pos: pos, phase: ph};
    directed_rows.push_back(row);
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    enc_result_t want;
    enc_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.code  = m_tdata[3:0];
      got.pos   = m_tdata[19:4];
      got.phase = m_tdata[21:20];
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%06h with no transaction pending", m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.code !== want.code)
          report_mismatch($sformatf("event_code %0d, predicted %0d", got.code, want.code));
        if (got.pos !== want.pos)
          report_mismatch($sformatf("position 0x%04h, predicted 0x%04h", got.pos, want.pos));
        if (got.phase !== want.phase)
          report_mismatch($sformatf("key_phase %0d, predicted %0d", got.phase, want.phase));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls
  initial begin : sink_pacing
    int unsigned hold;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (no_idle || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else begin
        m_tready <= 1'b0;
        hold = idle_span(1'b0);
      end
      repeat (hold) @(negedge clk);
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    no_idle        = 1'b0;
    items_sent     = 0;
    cfg_reverse    = 1'b0;
    cfg_long_ticks = LONG_TICKS_RST;
    cfg_min_ticks  = MIN_TICKS_RST;
    armed_st       = 1'b0;
    b_latched_st   = 1'b0;
    last_move_st   = MOVE_NONE;
    detent_st      = '0;
    phase_st       = PH_IDLE;
    press_start_st = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset configuration
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_UNKNOWN, 1, 1, 1, 32'hFFFFFFFF, 1, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     0, 1, 0, 32'h0,        1, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     1, 0, 0, 32'h0,        1, EV_NONE,      16'h0001, PH_IDLE);
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_UP,        16'h0001, PH_IDLE);
    add_row(REQ_PIN,     0, 0, 1, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     0, 1, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     1, 1, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_DOWN,      16'h0000, PH_IDLE);
    // equal b levels
    add_row(REQ_PIN,     0, 1, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     1, 1, 0, 32'h0,        1, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     1, 0, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    // press, read while pressed, early release, short press
    add_row(REQ_KEY,     0, 0, 0, 32'd100,      1, EV_NONE,      16'h0000, PH_PRESSED);
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_NONE,      16'h0000, PH_PRESSED);
    add_row(REQ_KEY,     0, 0, 1, 32'd105,      1, EV_NONE,      16'h0000, PH_PRESSED);
    add_row(REQ_KEY,     0, 0, 1, 32'd110,      1, EV_NONE,      16'h0000, PH_SHORT);
    add_row(REQ_KEY,     1, 1, 0, 32'd120,      0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_SHORT,     16'h0000, PH_SHORT);
    // long press across the tick wrap, with a down step
    add_row(REQ_KEY,     0, 0, 1, 32'd200,      0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_KEY,     0, 0, 0, 32'hFFFFFF00, 0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_KEY,     0, 0, 0, 32'h000002F0, 1, EV_NONE,      16'h0000, PH_LONG);
    add_row(REQ_PIN,     0, 0, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_PIN,     1, 1, 0, 32'h0,        0, EV_NONE,      16'h0000, PH_IDLE);
    add_row(REQ_READ,    0, 0, 0, 32'h0,        1, EV_LONG_DOWN, 16'hFFFF, PH_LONG);
    add_row(REQ_KEY,     0, 0, 1, 32'hFFFFFFFF, 0, EV_NONE,      16'h0000, PH_IDLE);
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].typed,
                                         directed_rows[i].res);

    // random phases over several register settings
    for (int phase_idx = 1; phase_idx <= 5; phase_idx++) begin
      settle();
      case (phase_idx)
        1: write_config(1'b1, 16'd65535, 16'd0);
        2: write_config(1'b0, 16'd1, 16'd65535);
        3: write_config(1'b1, 16'd0, 16'd0);   // zero long threshold
        4: write_config(1'b0, 16'd40, 16'd15);
        default: write_config(1'($urandom), 16'($urandom_range(1, 3000)),
                              16'($urandom_range(0, 3000)));
      endcase
      if (phase_idx == 4) begin
        // gapless run of detents one way and back
        no_idle = 1'b1;
        repeat (SPIN_DETENTS) run_detent(1'b1, 1'b0);
        repeat (SPIN_DETENTS) run_detent(1'b0, 1'b0);
        no_idle = 1'b0;
      end
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rekp_pkg.sv
rtl/core/rekp_cfg.sv
rtl/core/rekp_core.sv
rtl/core/rotary_encoder_with_key_press.sv
rtl/core/rekp_chk.sv
dv/tb_top.sv
